[hw/rtl/srsi_pkg.sv]
// ----------------------------------------------------------------------------
// srsi_pkg - shared definitions for the slotted ring station
// Register indexes, field widths and reset values used by the station and
// its testbench.
// ----------------------------------------------------------------------------
package srsi_pkg;

   // field widths
   localparam int unsigned TAG_W    = 8;
   localparam int unsigned PERIOD_W = 8;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned QCOUNT_W = 10;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STATION_ID     = 2'd0,
      CSR_HOLDOFF_PERIOD = 2'd1,
      CSR_PRIORITY_MODE  = 2'd2
   } csr_index_type;

   // register reset values
   localparam logic [TAG_W-1:0]    STATION_ID_RST     = 8'd0;
   localparam logic [PERIOD_W-1:0] HOLDOFF_PERIOD_RST = 8'd10;

endpackage

[hw/rtl/srsi_ram.sv]
// ----------------------------------------------------------------------------
// srsi_ram - simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module srsi_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/slotted_ring_station_insertion.sv]
// ----------------------------------------------------------------------------
// slotted_ring_station_insertion - one station of a slotted ring
// Queues PDU arrival stamps, frees returning own slots and inserts the head
// PDU into empty slots under a hold-off countdown.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one passing slot per transaction (occupancy, owner tag and
//   an arrival flag); each accepted transaction advances slot time by one.
//   rsp_* returns exactly one result per request: the leaving slot, the
//   freed/inserted flags, the waiting delay of an inserted PDU, the queue
//   fill after the step and a drop flag for an arrival into a full queue.
//   csr_* writes station_id, holdoff_period and priority_mode; write it only
//   while no transaction is in flight.
// Timing: a result appears in the cycle after its request is accepted;
//   one request per cycle is taken unless a pending result stalls. The head
//   stamp is kept prefetched from the stamp RAM (registered read plus a
//   write bypass), so each step is a single pass.
// Reset:
//   Synchronous; the queue is empty, slot time and countdown are zero and
//   the registers take their defaults. The stamp RAM is not cleared.
// Stall:
//   When rsp_ready is low with a result pending, req_ready drops and the
//   station state holds until the result is taken.
// ----------------------------------------------------------------------------
module slotted_ring_station_insertion #(
   parameter int unsigned QUEUE_DEPTH = 512
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_slot_occupied,
   input  logic [srsi_pkg::TAG_W-1:0]           req_slot_owner,
   input  logic                                 req_pdu_arrival,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_out_occupied,
   output logic [srsi_pkg::TAG_W-1:0]           rsp_out_owner,
   output logic                                 rsp_freed_own,
   output logic                                 rsp_inserted,
   output logic [srsi_pkg::TIME_W-1:0]          rsp_wait_delay,
   output logic [srsi_pkg::QCOUNT_W-1:0]        rsp_queue_count,
   output logic                                 rsp_arrival_dropped,
   // configuration port
   input  logic                                 csr_we,
   input  logic [srsi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [srsi_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   // configuration registers
   logic [srsi_pkg::TAG_W-1:0]    station_id_ff;
   logic [srsi_pkg::PERIOD_W-1:0] holdoff_period_ff;
   logic                          priority_mode_ff;

   // station state
   logic [srsi_pkg::TIME_W-1:0]   slot_time_ff, slot_time_in;
   logic [srsi_pkg::PERIOD_W-1:0] holdoff_ff, holdoff_in;
   logic [PTR_W-1:0]              head_ff, head_in;
   logic [PTR_W-1:0]              tail_ff, tail_in;
   logic [CNT_W-1:0]              count_ff, count_in;

   // head stamp bypass
   logic                          bypass_ff;
   logic [srsi_pkg::TIME_W-1:0]   bypass_data_ff;
   logic [srsi_pkg::TIME_W-1:0]   ram_rd_data;
   logic [srsi_pkg::TIME_W-1:0]   head_stamp;

   // response registers
   logic                          rsp_valid_ff;
   logic                          occupied_ff, occupied_in;
   logic [srsi_pkg::TAG_W-1:0]    owner_ff, owner_in;
   logic                          freed_ff, freed_in;
   logic                          inserted_ff, inserted_in;
   logic [srsi_pkg::TIME_W-1:0]   delay_ff, delay_in;
   logic [srsi_pkg::QCOUNT_W-1:0] qcount_ff, qcount_in;
   logic                          dropped_ff, dropped_in;

   logic fire;
   logic push;
   logic pushed_count_nz;
   logic [CNT_W-1:0] count_pushed;
   logic slot_busy;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         station_id_ff     <= srsi_pkg::STATION_ID_RST;
         holdoff_period_ff <= srsi_pkg::HOLDOFF_PERIOD_RST;
         priority_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (srsi_pkg::csr_index_type'(csr_index))
            srsi_pkg::CSR_STATION_ID: begin
               station_id_ff <= csr_wdata[srsi_pkg::TAG_W-1:0];
            end
            srsi_pkg::CSR_HOLDOFF_PERIOD: begin
               holdoff_period_ff <= csr_wdata[srsi_pkg::PERIOD_W-1:0];
            end
            srsi_pkg::CSR_PRIORITY_MODE: begin
               priority_mode_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // head stamp: queue empty means the only candidate is this step's arrival
   assign head_stamp = (count_ff == '0) ? slot_time_ff :
                       (bypass_ff ? bypass_data_ff : ram_rd_data);

   // one slot step
   always_comb begin
      push         = req_pdu_arrival && (count_ff != DEPTH_C);
      dropped_in   = req_pdu_arrival && (count_ff == DEPTH_C);
      count_pushed = push ? count_ff + 1'b1 : count_ff;
      tail_in      = tail_ff;
      if (fire && push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      pushed_count_nz = (count_pushed != '0);

      // free own returning PDU
      freed_in  = req_slot_occupied && (req_slot_owner == station_id_ff);
      slot_busy = req_slot_occupied && !freed_in;

      // insertion
      inserted_in = !slot_busy && (priority_mode_ff || !freed_in) &&
                    (holdoff_ff == '0) && pushed_count_nz;

      head_in     = head_ff;
      count_in    = count_ff;
      holdoff_in  = holdoff_ff;
      delay_in    = '0;
      if (inserted_in) begin
         delay_in = slot_time_ff - head_stamp;
      end
      if (fire) begin
         count_in = inserted_in ? count_pushed - 1'b1 : count_pushed;
         if (inserted_in) begin
            head_in    = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
            holdoff_in = (holdoff_period_ff == '0) ? '0 : holdoff_period_ff - 1'b1;
         end else if (holdoff_ff != '0) begin
            holdoff_in = holdoff_ff - 1'b1;
         end
      end

      occupied_in = slot_busy || inserted_in;
      if (inserted_in) begin
         owner_in = station_id_ff;
      end else if (slot_busy) begin
         owner_in = req_slot_owner;
      end else begin
         owner_in = '0;
      end

      qcount_in    = srsi_pkg::QCOUNT_W'(count_in);
      slot_time_in = fire ? slot_time_ff + 1'b1 : slot_time_ff;
   end

   // state and bypass registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_time_ff <= '0;
         holdoff_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         bypass_ff    <= 1'b0;
      end else begin
         slot_time_ff <= slot_time_in;
         holdoff_ff   <= holdoff_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         bypass_ff    <= fire && push && (tail_ff == head_in);
      end
   end

   always_ff @(posedge clock) begin
      bypass_data_ff <= slot_time_ff;
   end

   // stamp memory, read address follows the next head
   srsi_ram #(
      .WIDTH (srsi_pkg::TIME_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (fire && push),
      .wr_addr (tail_ff),
      .wr_data (slot_time_ff),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         occupied_ff <= occupied_in;
         owner_ff    <= owner_in;
         freed_ff    <= freed_in;
         inserted_ff <= inserted_in;
         delay_ff    <= delay_in;
         qcount_ff   <= qcount_in;
         dropped_ff  <= dropped_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_occupied    = occupied_ff;
   assign rsp_out_owner       = owner_ff;
   assign rsp_freed_own       = freed_ff;
   assign rsp_inserted        = inserted_ff;
   assign rsp_wait_delay      = delay_ff;
   assign rsp_queue_count     = qcount_ff;
   assign rsp_arrival_dropped = dropped_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("queue count above depth");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (fire && req_pdu_arrival && count_ff == DEPTH_C) |=> rsp_arrival_dropped)
      else $error("arrival into full queue not flagged");

   a_insert_owner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && inserted_ff) |-> (occupied_ff && owner_ff == station_id_ff))
      else $error("inserted slot not tagged with station id");

   a_reuse_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && inserted_ff && freed_ff) |-> priority_mode_ff)
      else $error("freed slot reused outside priority mode");

   a_holdoff_load: assert property (@(posedge clock) disable iff (reset)
      (fire && inserted_in && holdoff_period_ff != '0) |=>
      (holdoff_ff == $past(holdoff_period_ff) - 1'b1))
      else $error("hold-off countdown not loaded on insertion");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb - self-checking testbench for slotted_ring_station_insertion
// Drives passing slots through the request channel with bursty traffic and
// a stalling response side. A scoreboard class follows the station's FIFO,
// hold-off countdown and slot time, and checks every response field. Phases
// between register writes cover normal and priority mode, zero and maximum
// hold-off, a flood that fills the FIFO to overflow, and a drain.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned STAMP_DEPTH = 512;
   localparam int unsigned RUN_LIMIT   = 3000000;
   // index with no register behind it; writes there are ignored
   localparam logic [srsi_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct packed {
      logic                          out_occupied;
      logic [srsi_pkg::TAG_W-1:0]    out_owner;
      logic                          freed_own;
      logic                          inserted;
      logic [srsi_pkg::TIME_W-1:0]   wait_delay;
      logic [srsi_pkg::QCOUNT_W-1:0] queue_count;
      logic                          arrival_dropped;
   } slot_result_type;

   // scoreboard: shadow station state and the expected slot decisions
   class station_tracker_type;
      logic [srsi_pkg::TAG_W-1:0]    station_id;
      logic [srsi_pkg::PERIOD_W-1:0] holdoff_period;
      logic                          priority_mode;
      logic [srsi_pkg::TIME_W-1:0]   slot_time;
      logic [srsi_pkg::PERIOD_W-1:0] holdoff_count;
      logic [srsi_pkg::TIME_W-1:0]   stamps [STAMP_DEPTH];
      int unsigned                   head_ptr;
      int unsigned                   tail_ptr;
      int unsigned                   waiting;
      slot_result_type               expected_slots [$];
      int unsigned                   errors;

      function new();
         station_id     = srsi_pkg::STATION_ID_RST;
         holdoff_period = srsi_pkg::HOLDOFF_PERIOD_RST;
         priority_mode  = 1'b0;
         slot_time      = '0;
         holdoff_count  = '0;
         head_ptr       = 0;
         tail_ptr       = 0;
         waiting        = 0;
         errors         = 0;
      endfunction

      function void write_reg(logic [srsi_pkg::CSR_IDX_W-1:0] idx,
                              logic [srsi_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            srsi_pkg::CSR_STATION_ID:     station_id     = data;
            srsi_pkg::CSR_HOLDOFF_PERIOD: holdoff_period = data;
            srsi_pkg::CSR_PRIORITY_MODE:  priority_mode  = data[0];
            default: ;
         endcase
      endfunction

      // one step of the station for an accepted slot transaction
      function void note_slot(logic occ, logic [srsi_pkg::TAG_W-1:0] owner, logic arrival);
         slot_result_type            r;
         logic                       busy;
         logic [srsi_pkg::TAG_W-1:0] tag;
         busy = occ;
         tag  = owner;
         r    = '0;
         // arrival is stamped with the current slot time
         if (arrival) begin
            if (waiting < STAMP_DEPTH) begin
               stamps[tail_ptr] = slot_time;
               tail_ptr = (tail_ptr + 1) % STAMP_DEPTH;
               waiting++;
            end else begin
               r.arrival_dropped = 1'b1;
            end
         end
         // own PDU back around the ring
         if (busy && tag == station_id) begin
            r.freed_own = 1'b1;
            busy = 1'b0;
         end
         // insertion of the head PDU
         if (!busy && (priority_mode || !r.freed_own) && holdoff_count == 0 && waiting > 0) begin
            r.inserted   = 1'b1;
            busy         = 1'b1;
            tag          = station_id;
            r.wait_delay = slot_time - stamps[head_ptr];
            head_ptr     = (head_ptr + 1) % STAMP_DEPTH;
            waiting--;
            holdoff_count = holdoff_period;
         end
         if (!busy)
            tag = '0;
         if (holdoff_count != 0)
            holdoff_count--;
         slot_time++;
         r.out_occupied = busy;
         r.out_owner    = tag;
         r.queue_count  = waiting[srsi_pkg::QCOUNT_W-1:0];
         expected_slots.push_back(r);
      endfunction

      function void check_field(string field, logic [srsi_pkg::TIME_W-1:0] want,
                                logic [srsi_pkg::TIME_W-1:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_slot(slot_result_type got);
         slot_result_type want;
         if (expected_slots.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none actual %0h", $time, got);
         end else begin
            want = expected_slots.pop_front();
            check_field("out_occupied", srsi_pkg::TIME_W'(want.out_occupied),
                        srsi_pkg::TIME_W'(got.out_occupied));
            check_field("out_owner", srsi_pkg::TIME_W'(want.out_owner),
                        srsi_pkg::TIME_W'(got.out_owner));
            check_field("freed_own", srsi_pkg::TIME_W'(want.freed_own),
                        srsi_pkg::TIME_W'(got.freed_own));
            check_field("inserted", srsi_pkg::TIME_W'(want.inserted),
                        srsi_pkg::TIME_W'(got.inserted));
            check_field("wait_delay", want.wait_delay, got.wait_delay);
            check_field("queue_count", srsi_pkg::TIME_W'(want.queue_count),
                        srsi_pkg::TIME_W'(got.queue_count));
            check_field("arrival_dropped", srsi_pkg::TIME_W'(want.arrival_dropped),
                        srsi_pkg::TIME_W'(got.arrival_dropped));
         end
      endfunction

      function int unsigned pending();
         return expected_slots.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_slot_occupied = 1'b0;
   logic [srsi_pkg::TAG_W-1:0]      req_slot_owner = '0;
   logic                            req_pdu_arrival = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_out_occupied;
   logic [srsi_pkg::TAG_W-1:0]      rsp_out_owner;
   logic                            rsp_freed_own;
   logic                            rsp_inserted;
   logic [srsi_pkg::TIME_W-1:0]     rsp_wait_delay;
   logic [srsi_pkg::QCOUNT_W-1:0]   rsp_queue_count;
   logic                            rsp_arrival_dropped;
   logic                            csr_we = 1'b0;
   logic [srsi_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [srsi_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   station_tracker_type board;
   int                  burst_left = 0;

   slotted_ring_station_insertion #(.QUEUE_DEPTH(STAMP_DEPTH)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_slot_occupied   (req_slot_occupied),
      .req_slot_owner      (req_slot_owner),
      .req_pdu_arrival     (req_pdu_arrival),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_occupied    (rsp_out_occupied),
      .rsp_out_owner       (rsp_out_owner),
      .rsp_freed_own       (rsp_freed_own),
      .rsp_inserted        (rsp_inserted),
      .rsp_wait_delay      (rsp_wait_delay),
      .rsp_queue_count     (rsp_queue_count),
      .rsp_arrival_dropped (rsp_arrival_dropped),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // one slot transaction; sender idles for a random gap, possibly none, between bursts of random length
   task automatic send_slot(input logic occ, input logic [srsi_pkg::TAG_W-1:0] owner,
                            input logic arrival);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 7);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_slot_occupied <= occ;
      req_slot_owner    <= owner;
      req_pdu_arrival   <= arrival;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_slot(occ, owner, arrival);
      burst_left--;
   endtask

   // stop sending and wait until every response is back
   task automatic quiesce();
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [srsi_pkg::CSR_IDX_W-1:0] idx,
                            input logic [srsi_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      board.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic program_station(input logic [srsi_pkg::TAG_W-1:0] id,
                                  input logic [srsi_pkg::PERIOD_W-1:0] period,
                                  input logic prio);
      logic [31:0]                     rnd;
      logic [srsi_pkg::CSR_DATA_W-2:0] junk;
      rnd  = $urandom;
      junk = rnd[srsi_pkg::CSR_DATA_W-2:0];
      quiesce();
      write_csr(srsi_pkg::CSR_STATION_ID, id);
      write_csr(srsi_pkg::CSR_HOLDOFF_PERIOD, period);
      // upper bits of the mode write are don't-care
      write_csr(srsi_pkg::CSR_PRIORITY_MODE, {junk, prio});
      csr_we <= 1'b0;
   endtask

   // random slots; percentages set occupancy, own-tag share and arrivals
   task automatic run_random(input int unsigned n, input int unsigned occ_pct,
                             input int unsigned own_pct, input int unsigned arr_pct);
      logic                       occ;
      logic                       arrival;
      logic [srsi_pkg::TAG_W-1:0] owner;
      repeat (n) begin
         occ     = ($urandom_range(0, 99) < occ_pct);
         arrival = ($urandom_range(0, 99) < arr_pct);
         if ($urandom_range(0, 99) < own_pct)
            owner = board.station_id;
         else
            owner = board.station_id ^ srsi_pkg::TAG_W'($urandom_range(1, 255));
         send_slot(occ, owner, arrival);
      end
   endtask

   // response side: rsp_ready follows a stall pattern drawn at random from four modes
   initial begin : response_side
      int unsigned cyc;
      int unsigned mode;
      int unsigned hold;
      cyc  = 0;
      mode = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_slot({rsp_out_occupied, rsp_out_owner, rsp_freed_own, rsp_inserted,
                              rsp_wait_delay, rsp_queue_count, rsp_arrival_dropped});
         cyc++;
         if (cyc % 48 == 0)
            mode = $urandom_range(0, 3);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) != 0);
               2: rsp_ready <= (cyc % 3 == 0);
               default: begin
                  if (hold == 0) begin
                     hold = $urandom_range(1, 16);
                     rsp_ready <= 1'b1;
                  end else begin
                     hold--;
                     rsp_ready <= (hold == 0);
                  end
               end
            endcase
         end
      end
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // register defaults: station 0, hold-off 10, normal mode
      send_slot(1'b0, 8'h00, 1'b0);
      // empty slot carrying a tag, arrival inserted at once
      send_slot(1'b0, 8'hFF, 1'b1);
      // own slot in normal mode: freed, left empty
      send_slot(1'b1, 8'h00, 1'b0);
      repeat (3) send_slot(1'b1, 8'h80, 1'b1);
      // empty slots while the countdown runs out
      repeat (6) send_slot(1'b0, 8'h55, 1'b0);

      // top station tag, zero hold-off, priority mode
      program_station(8'hFF, 8'd0, 1'b1);
      quiesce();
      write_csr(CSR_SPARE_INDEX, 8'hAA);
      csr_we <= 1'b0;
      send_slot(1'b1, 8'hFF, 1'b1);
      send_slot(1'b1, 8'hFF, 1'b1);
      send_slot(1'b1, 8'hFF, 1'b0);
      send_slot(1'b0, 8'h00, 1'b0);
      send_slot(1'b1, 8'h00, 1'b1);
      send_slot(1'b0, 8'h7F, 1'b1);

      // own slot in normal mode with PDUs waiting
      program_station(8'hFF, 8'd0, 1'b0);
      send_slot(1'b1, 8'hFF, 1'b1);
      send_slot(1'b1, 8'hFF, 1'b0);
      send_slot(1'b0, 8'h01, 1'b0);
      send_slot(1'b0, 8'hFE, 1'b0);

      // random phases over several register settings
      program_station(8'h5A, 8'd3, 1'b0);
      run_random(150, 50, 40, 40);
      program_station(8'h00, 8'd0, 1'b1);
      run_random(150, 60, 50, 50);
      program_station(8'hFF, 8'd255, 1'b1);
      run_random(100, 40, 50, 60);
      // flood: every slot taken by others, FIFO fills and overflows
      program_station(srsi_pkg::TAG_W'($urandom_range(0, 255)), 8'd255, 1'b0);
      run_random(540, 100, 0, 100);
      // drain with zero hold-off
      program_station(board.station_id, 8'd0, 1'b0);
      run_random(560, 5, 50, 10);
      program_station(srsi_pkg::TAG_W'($urandom_range(0, 255)), 8'd1, 1'b1);
      run_random(150, 50, 50, 50);

      quiesce();
      if (board.errors == 0 && board.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

[filelist.f]
hw/rtl/srsi_pkg.sv
hw/rtl/srsi_ram.sv
hw/rtl/slotted_ring_station_insertion.sv
tb/tb.sv
